// ===== src/tlq_pkg.sv =====
// Package for the three-level ready queue scheduler.
// Holds widths, opcodes, status codes and the controller/datapath command structs.
package tlq_pkg;
   localparam int SLOTS = 16;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DISPATCH = 2'd1;
   localparam logic [1:0] OP_AGE = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic [1:0] CSR_AGING_STEP = 2'd0;
   localparam logic [1:0] CSR_AGING_LIMIT = 2'd1;
   localparam logic [1:0] CSR_PRIORITY_BOOST = 2'd2;

   localparam logic [7:0] PRIO_REJECT = 8'd150;
   localparam logic [7:0] PRIO_MAX = 8'd149;
   localparam logic [7:0] BAND_L1 = 8'd100;
   localparam logic [7:0] BAND_L2 = 8'd50;

   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_step;
      logic do_insert;
      logic do_remove;
      logic do_age;
      logic [SLOT_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic reject;
      logic have_best;
      logic [7:0] best_id;
      logic preempt;
   } sts_type;

   function automatic logic [1:0] band_of(input logic [7:0] p);
      if (p >= BAND_L1) return 2'd1;
      else if (p >= BAND_L2) return 2'd2;
      else return 2'd3;
   endfunction
endpackage

// ===== src/three_level_ready_queue_scheduler_top.sv =====
// Each accepted word is scanned across every slot and then applied; its result word is held until taken.
// The input stalls while a word is in work or its result waits.
// Synchronous active-high reset empties the table, zeroes the arrival counter
// and loads the register defaults: step 100, limit 400, boost 10.
module three_level_ready_queue_scheduler_top (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_thread_id,
   input  logic [7:0] req_priority_req,
   input  logic [15:0] req_remaining_burst,
   input  logic [15:0] req_running_burst,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic rsp_preempt,
   output logic rsp_picked_valid,
   output logic [7:0] rsp_picked_id
);
   import tlq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tlq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_preempt(rsp_preempt), .rsp_picked_valid(rsp_picked_valid),
      .rsp_picked_id(rsp_picked_id), .cmd(cmd), .sts(sts)
   );

   tlq_dp u_dp (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_thread_id(req_thread_id), .req_priority_req(req_priority_req),
      .req_remaining_burst(req_remaining_burst), .req_running_burst(req_running_burst),
      .cmd(cmd), .sts(sts)
   );
endmodule

// ===== src/tlq_ctrl.sv =====
// Controller state machine of the scheduler.
// Walks the slots one per cycle and issues commands to tlq_dp; uses tlq_pkg.
module tlq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_op,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic rsp_preempt,
   output logic rsp_picked_valid,
   output logic [7:0] rsp_picked_id,
   output tlq_pkg::cmd_type cmd,
   input  tlq_pkg::sts_type sts
);
   import tlq_pkg::*;

   typedef enum logic [1:0] {IDLE, SCAN, APPLY, DONE} state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] status_ff, status_in;
   logic preempt_ff, preempt_in, pv_ff, pv_in;
   logic [7:0] pid_ff, pid_in;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = (state_ff == DONE);
   assign rsp_status = status_ff;
   assign rsp_preempt = preempt_ff;
   assign rsp_picked_valid = pv_ff;
   assign rsp_picked_id = pid_ff;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      status_in = status_ff;
      preempt_in = preempt_ff;
      pv_in = pv_ff;
      pid_in = pid_ff;
      cmd = '0;
      cmd.idx = cnt_ff[SLOT_W-1:0];
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.scan_clear = 1'b1;
               op_in = req_op;
               cnt_in = '0;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.do_age = (op_ff == OP_AGE);
            if (cnt_ff == CNT_W'(SLOTS - 1)) state_in = APPLY;
            cnt_in = cnt_ff + 1'b1;
         end
         APPLY: begin
            status_in = ST_OK;
            preempt_in = 1'b0;
            pv_in = 1'b0;
            pid_in = '0;
            if (op_ff == OP_INSERT) begin
               if (sts.reject) status_in = ST_REJECT;
               else if (sts.full) status_in = ST_FULL;
               else begin
                  cmd.do_insert = 1'b1;
                  preempt_in = sts.preempt;
               end
            end else if (op_ff == OP_DISPATCH) begin
               if (!sts.have_best) status_in = ST_EMPTY;
               else begin
                  cmd.do_remove = 1'b1;
                  pv_in = 1'b1;
                  pid_in = sts.best_id;
               end
            end
            state_in = DONE;
         end
         DONE: begin
            if (!rsp_stall) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      status_ff <= status_in;
      preempt_ff <= preempt_in;
      pv_ff <= pv_in;
      pid_ff <= pid_in;
   end
endmodule

// ===== src/tlq_dp.sv =====
// Datapath of the scheduler: slot table, configuration registers and scan unit.
// Driven by tlq_ctrl commands; uses tlq_pkg.
module tlq_dp (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data,
   input  logic [7:0] req_thread_id,
   input  logic [7:0] req_priority_req,
   input  logic [15:0] req_remaining_burst,
   input  logic [15:0] req_running_burst,
   input  tlq_pkg::cmd_type cmd,
   output tlq_pkg::sts_type sts
);
   import tlq_pkg::*;

   logic [SLOTS-1:0] valid_ff;
   logic [7:0] thread_ff [SLOTS];
   logic [7:0] prio_ff [SLOTS];
   logic [15:0] burst_ff [SLOTS];
   logic [15:0] wait_ff [SLOTS];
   logic [1:0] level_ff [SLOTS];
   logic [15:0] stamp_ff [SLOTS];
   logic [15:0] arrival_ff;
   logic [9:0] step_ff;
   logic [15:0] limit_ff;
   logic [5:0] boost_ff;

   logic [7:0] id_ff, p_ff;
   logic [15:0] b_ff, run_ff;

   logic free_found_ff;
   logic [SLOT_W-1:0] free_ff, best_ff;
   logic best_found_ff;
   logic [1:0] blv_ff;
   logic [15:0] bburst_ff, bage_ff;
   logic [7:0] bid_ff;

   logic [SLOT_W-1:0] i;
   logic [15:0] age_i;
   logic better;
   logic [16:0] wsum;
   logic [15:0] wsat;
   logic [8:0] psum;
   logic [7:0] pnew;
   logic over;

   assign i = cmd.idx;
   assign age_i = arrival_ff - stamp_ff[i];

   always_comb begin
      better = 1'b0;
      if (!best_found_ff || level_ff[i] < blv_ff) better = 1'b1;
      else if (level_ff[i] == blv_ff) begin
         if (blv_ff == 2'd1 && burst_ff[i] != bburst_ff) better = burst_ff[i] < bburst_ff;
         else if (blv_ff == 2'd2 && thread_ff[i] != bid_ff) better = thread_ff[i] < bid_ff;
         else better = age_i > bage_ff;
      end
      wsum = {1'b0, wait_ff[i]} + 17'(step_ff);
      wsat = wsum[16] ? 16'hFFFF : wsum[15:0];
      over = wsat > limit_ff;
      psum = {1'b0, prio_ff[i]} + 9'(boost_ff);
      pnew = (psum > 9'(PRIO_MAX)) ? PRIO_MAX : psum[7:0];
   end

   assign sts.full = !free_found_ff;
   assign sts.reject = p_ff >= PRIO_REJECT;
   assign sts.have_best = best_found_ff;
   assign sts.best_id = bid_ff;
   assign sts.preempt = (band_of(p_ff) == 2'd1) && (b_ff < run_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         arrival_ff <= '0;
         step_ff <= 10'd100;
         limit_ff <= 16'd400;
         boost_ff <= 6'd10;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_AGING_STEP: step_ff <= csr_data[9:0];
               CSR_AGING_LIMIT: limit_ff <= csr_data;
               CSR_PRIORITY_BOOST: boost_ff <= csr_data[5:0];
               default: ;
            endcase
         end
         if (cmd.do_insert) begin
            valid_ff[free_ff] <= 1'b1;
            arrival_ff <= arrival_ff + 16'd1;
         end
         if (cmd.do_remove) valid_ff[best_ff] <= 1'b0;
      end
      if (cmd.load) begin
         id_ff <= req_thread_id;
         p_ff <= req_priority_req;
         b_ff <= req_remaining_burst;
         run_ff <= req_running_burst;
      end
      if (cmd.scan_clear) begin
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end
      if (cmd.scan_step && valid_ff[i] && !cmd.do_age && better) begin
         best_found_ff <= 1'b1;
         best_ff <= i;
         blv_ff <= level_ff[i];
         bburst_ff <= burst_ff[i];
         bid_ff <= thread_ff[i];
         bage_ff <= age_i;
      end
      if (cmd.scan_step && !valid_ff[i] && !free_found_ff) begin
         free_found_ff <= 1'b1;
         free_ff <= i;
      end
      if (cmd.scan_step && cmd.do_age && valid_ff[i]) begin
         if (over) begin
            prio_ff[i] <= pnew;
            level_ff[i] <= band_of(pnew);
            wait_ff[i] <= (level_ff[i] != 2'd1) ? 16'd0 : wsat;
         end else begin
            wait_ff[i] <= wsat;
            level_ff[i] <= band_of(prio_ff[i]);
         end
      end
      if (cmd.do_insert) begin
         thread_ff[free_ff] <= id_ff;
         prio_ff[free_ff] <= p_ff;
         burst_ff[free_ff] <= b_ff;
         wait_ff[free_ff] <= '0;
         level_ff[free_ff] <= band_of(p_ff);
         stamp_ff[free_ff] <= arrival_ff;
      end
   end
endmodule

// ===== src/tlq_checker.sv =====
// Port-level checker for the scheduler top level, with its bind statement.
// Depends on three_level_ready_queue_scheduler_top port names and tlq_pkg.
module tlq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [1:0] rsp_status,
   input logic rsp_preempt,
   input logic rsp_picked_valid,
   input logic [7:0] rsp_picked_id
);
   import tlq_pkg::*;

   a_stall_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input open while result waits");
   a_pick_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_picked_valid |-> rsp_status == ST_OK && !rsp_preempt)
      else $error("pick with bad status");
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_picked_valid |-> rsp_picked_id == 8'd0)
      else $error("stray id");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_picked_id))
      else $error("result dropped");
endmodule

bind three_level_ready_queue_scheduler_top tlq_checker u_tlq_checker (.*);

// ===== bench/tb_three_level_ready_queue_scheduler_top.sv =====
// Self-checking bench for the three-level ready queue scheduler top.
// Predicts each result word from an internal slot table and checks it in order.
// Depends on tlq_pkg and three_level_ready_queue_scheduler_top.
module tb_three_level_ready_queue_scheduler_top;
   import tlq_pkg::*;

   typedef struct packed {
      logic [1:0] status;
      logic preempt;
      logic picked_valid;
      logic [7:0] picked_id;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_AGING_STEP;
   logic [15:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = OP_INSERT;
   logic [7:0] req_thread_id = '0;
   logic [7:0] req_priority_req = '0;
   logic [15:0] req_remaining_burst = '0;
   logic [15:0] req_running_burst = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_preempt;
   logic rsp_picked_valid;
   logic [7:0] rsp_picked_id;

   three_level_ready_queue_scheduler_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted scheduler state.
   logic        tbl_valid [SLOTS];
   logic [7:0]  tbl_thread [SLOTS];
   logic [7:0]  tbl_prio [SLOTS];
   logic [15:0] tbl_burst [SLOTS];
   logic [15:0] tbl_wait [SLOTS];
   logic [1:0]  tbl_level [SLOTS];
   logic [15:0] tbl_stamp [SLOTS];
   logic [15:0] arrivals;
   logic [9:0]  step_cfg;
   logic [15:0] limit_cfg;
   logic [5:0]  boost_cfg;

   sched_result_type pending_results[$];
   int mismatches = 0;
   int words_checked = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;

   function automatic logic [1:0] level_for(input logic [7:0] p);
      if (p >= BAND_L1) return 2'd1;
      if (p >= BAND_L2) return 2'd2;
      return 2'd3;
   endfunction

   function automatic logic serves_first(input int a, input int b);
      logic [15:0] age_a, age_b;
      age_a = arrivals - tbl_stamp[a];
      age_b = arrivals - tbl_stamp[b];
      if (tbl_level[a] == 2'd1 && tbl_burst[a] != tbl_burst[b])
         return tbl_burst[a] < tbl_burst[b];
      if (tbl_level[a] == 2'd2 && tbl_thread[a] != tbl_thread[b])
         return tbl_thread[a] < tbl_thread[b];
      if (age_a != age_b) return age_a > age_b;
      return a < b;
   endfunction

   function automatic sched_result_type schedule_word(input logic [1:0] op,
         input logic [7:0] tid, input logic [7:0] prio,
         input logic [15:0] burst, input logic [15:0] run);
      sched_result_type r;
      int slot;
      int unsigned w, p;
      r = '0;
      r.status = ST_OK;
      slot = -1;
      case (op)
         OP_INSERT: begin
            for (int i = SLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
            if (prio >= PRIO_REJECT) r.status = ST_REJECT;
            else if (slot < 0) r.status = ST_FULL;
            else begin
               tbl_valid[slot] = 1'b1;
               tbl_thread[slot] = tid;
               tbl_prio[slot] = prio;
               tbl_burst[slot] = burst;
               tbl_wait[slot] = '0;
               tbl_level[slot] = level_for(prio);
               tbl_stamp[slot] = arrivals;
               arrivals = arrivals + 16'd1;
               r.preempt = (tbl_level[slot] == 2'd1) && (burst < run);
            end
         end
         OP_DISPATCH: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!tbl_valid[i]) continue;
               if (slot < 0 || tbl_level[i] < tbl_level[slot] ||
                   (tbl_level[i] == tbl_level[slot] && serves_first(i, slot)))
                  slot = i;
            end
            if (slot < 0) r.status = ST_EMPTY;
            else begin
               tbl_valid[slot] = 1'b0;
               r.picked_valid = 1'b1;
               r.picked_id = tbl_thread[slot];
            end
         end
         OP_AGE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!tbl_valid[i]) continue;
               w = tbl_wait[i] + step_cfg;
               if (w > 65535) w = 65535;
               if (w > limit_cfg) begin
                  p = tbl_prio[i] + boost_cfg;
                  if (p > PRIO_MAX) p = PRIO_MAX;
                  tbl_prio[i] = p[7:0];
                  if (tbl_level[i] != 2'd1) w = 0;
               end
               tbl_wait[i] = w[15:0];
               tbl_level[i] = level_for(tbl_prio[i]);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [7:0] tid,
         input logic [7:0] prio, input logic [15:0] burst, input logic [15:0] run);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_op <= op;
      req_thread_id <= tid;
      req_priority_req <= prio;
      req_remaining_burst <= burst;
      req_running_burst <= run;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(schedule_word(op, tid, prio, burst, run));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (25) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_AGING_STEP: step_cfg = val[9:0];
         CSR_AGING_LIMIT: limit_cfg = val;
         CSR_PRIORITY_BOOST: boost_cfg = val[5:0];
         default: ;
      endcase
   endtask

   task automatic random_word(input int fill_bias);
      int pick;
      logic [7:0] prio;
      pick = $urandom_range(99);
      prio = ($urandom_range(9) == 0) ? 8'($urandom_range(150, 255))
                                      : 8'($urandom_range(0, 149));
      if (pick < fill_bias)
         send_word(OP_INSERT, 8'($urandom), prio, 16'($urandom), 16'($urandom));
      else if (pick < fill_bias + 30)
         send_word(OP_DISPATCH, 8'($urandom), 8'($urandom), 16'($urandom),
                   16'($urandom));
      else if (pick < 98)
         send_word(OP_AGE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      else
         send_word(OP_NOP, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic test_directed();
      send_word(OP_DISPATCH, 8'd0, 8'd0, 16'd0, 16'd0);
      send_word(OP_INSERT, 8'd1, 8'd150, 16'd5, 16'd9);
      send_word(OP_INSERT, 8'd2, 8'd255, 16'd5, 16'd9);
      send_word(OP_INSERT, 8'd10, 8'd0, 16'd0, 16'd0);
      send_word(OP_INSERT, 8'd255, 8'd49, 16'hFFFF, 16'hFFFF);
      send_word(OP_INSERT, 8'd200, 8'd50, 16'd3, 16'd0);
      send_word(OP_INSERT, 8'd20, 8'd99, 16'd3, 16'd0);
      send_word(OP_INSERT, 8'd30, 8'd100, 16'd7, 16'd8);
      send_word(OP_INSERT, 8'd31, 8'd149, 16'd7, 16'd7);
      send_word(OP_INSERT, 8'd32, 8'd120, 16'd0, 16'hFFFF);
      send_word(OP_NOP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_word(OP_AGE, 8'd0, 8'd0, 16'd0, 16'd0);
      for (int i = 0; i < 12; i++) send_word(OP_DISPATCH, 8'd0, 8'd0, 16'd0, 16'd0);
   endtask

   task automatic test_aging_settings();
      logic [15:0] steps[4] = '{16'd0, 16'd1023, 16'd100, 16'd700};
      logic [15:0] limits[4] = '{16'd0, 16'd65535, 16'd400, 16'd1500};
      logic [15:0] boosts[4] = '{16'd0, 16'd63, 16'd10, 16'd25};
      for (int s = 0; s < 4; s++) begin
         write_csr(CSR_AGING_STEP, steps[s]);
         write_csr(CSR_AGING_LIMIT, limits[s]);
         write_csr(CSR_PRIORITY_BOOST, boosts[s]);
         for (int i = 0; i < 60; i++) random_word(45);
      end
   endtask

   task automatic test_overflow_table();
      for (int i = 0; i < 20; i++)
         send_word(OP_INSERT, 8'($urandom), 8'($urandom_range(0, 149)), 16'($urandom),
                   16'($urandom));
      for (int i = 0; i < 20; i++) send_word(OP_DISPATCH, 8'd0, 8'd0, 16'd0, 16'd0);
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      for (int i = 0; i < 8; i++) random_word(50);
      drain();
   endtask

   task automatic test_random_phases();
      int pct_send[4] = '{0, 51, 0, 35};
      int pct_stall[4] = '{0, 0, 51, 35};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = pct_send[ph];
         stall_pct = pct_stall[ph];
         for (int i = 0; i < 385; i++) random_word((i % 60) < 30 ? 60 : 30);
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
         end else begin
            want = pending_results.pop_front();
            if (want.status !== rsp_status || want.preempt !== rsp_preempt ||
                want.picked_valid !== rsp_picked_valid ||
                want.picked_id !== rsp_picked_id) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result word: expected st=%0d pre=%0d pv=%0d id=%0d,",
                            " got st=%0d pre=%0d pv=%0d id=%0d"},
                     want.status, want.preempt, want.picked_valid, want.picked_id,
                     rsp_status, rsp_preempt, rsp_picked_valid, rsp_picked_id);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
      arrivals = '0;
      step_cfg = 10'd100;
      limit_cfg = 16'd400;
      boost_cfg = 6'd10;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow_table();
      test_backpressure();
      test_aging_settings();
      test_random_phases();
      drain();
      $display("Checked %0d result words over directed, table-full, back-pressure,",
               words_checked);
      $display("four register settings and four idle/stall phases.");
      if (mismatches == 0 && pending_results.size() == 0)
         $display("three_level_ready_queue_scheduler_top: match");
      else
         $display("three_level_ready_queue_scheduler_top: mismatch");
      $finish;
   end

   initial begin
      #5000000;
      $display("three_level_ready_queue_scheduler_top: mismatch");
      $finish;
   end
endmodule

// ===== three_level_ready_queue_scheduler_top.f =====
src/tlq_pkg.sv
src/tlq_ctrl.sv
src/tlq_dp.sv
src/three_level_ready_queue_scheduler_top.sv
src/tlq_checker.sv
bench/tb_three_level_ready_queue_scheduler_top.sv
